// File: sv/mtep_pkg.sv
// Shared types, codes and helpers for the MIDI track event parser.
// No dependencies; the RTL files refer to this package by scoped names, and the testbench imports it.
`default_nettype none

package mtep_pkg;

  // Byte constants of the track event syntax.
  localparam logic [7:0] STATUS_META  = 8'hff;
  localparam logic [7:0] STATUS_SYSEX = 8'hf0;
  localparam logic [7:0] STATUS_EOX   = 8'hf7;
  localparam logic [7:0] STATUS_CH_LO = 8'h80;
  localparam logic [7:0] STATUS_CH_HI = 8'hef;
  localparam logic [3:0] HI_PROGRAM   = 4'hc;
  localparam logic [3:0] HI_PRESSURE  = 4'hd;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CHAN  = 2'd0,
    KIND_SYSEX = 2'd1,
    KIND_META  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_DELTA  = 4'd1,
    PH_STATUS = 4'd2,
    PH_P1     = 4'd3,
    PH_P2     = 4'd4,
    PH_SYSEX  = 4'd5,
    PH_MTYPE  = 4'd6,
    PH_MLEN   = 4'd7,
    PH_MDATA  = 4'd8
  } phase_e;

  // One classified input byte, as held in the queue.
  typedef struct packed {
    logic       track_start;
    logic [7:0] data_byte;
    logic       is_status;
    logic       is_chan;
    logic       is_sysex;
    logic       is_meta;
    logic       is_eox;
  } byte_class_t;

  // Queue occupancy seen by front and back.
  typedef struct packed {
    logic full;
    logic avail;
  } queue_stat_t;

  // One result record.
  typedef struct packed {
    kind_e       record_kind;
    logic [31:0] time_stamp;
    logic [7:0]  status_value;
    logic [7:0]  param_first;
    logic [7:0]  param_second;
    logic [7:0]  meta_type;
    logic        payload_valid;
    logic        last_of_event;
    logic        running_allowed;
  } record_t;

  function automatic logic is_chan_status(input logic [7:0] st);
    return (st >= STATUS_CH_LO) && (st <= STATUS_CH_HI);
  endfunction

  function automatic logic is_one_param(input logic [7:0] st);
    return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
  endfunction

  // Build a record without time stamp and running flag; the caller fills those.
  function automatic record_t make_rec(input kind_e kind, input logic [7:0] st,
                                       input logic [7:0] p1, input logic [7:0] p2,
                                       input logic [7:0] mtype, input logic pvalid,
                                       input logic last);
    record_t r;
    r = '0;
    r.record_kind   = kind;
    r.status_value  = st;
    r.param_first   = p1;
    r.param_second  = p2;
    r.meta_type     = mtype;
    r.payload_valid = pvalid;
    r.last_of_event = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/mtep_if.sv
// Valid/ready channel interfaces for the MIDI track event parser.
// Input beat carries one track byte; output beat carries one parsed record.
`default_nettype none

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic       track_start;
  logic [7:0] data_byte;

  modport source (output valid, output track_start, output data_byte, input ready);
  modport sink   (input valid, input track_start, input data_byte, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [31:0] time_stamp;
  logic [7:0]  status_value;
  logic [7:0]  param_first;
  logic [7:0]  param_second;
  logic [7:0]  meta_type;
  logic        payload_valid;
  logic        last_of_event;
  logic        running_allowed;

  modport source (output valid, output record_kind, output time_stamp,
                  output status_value, output param_first, output param_second,
                  output meta_type, output payload_valid, output last_of_event,
                  output running_allowed, input ready);
  modport sink   (input valid, input record_kind, input time_stamp,
                  input status_value, input param_first, input param_second,
                  input meta_type, input payload_valid, input last_of_event,
                  input running_allowed, output ready);
endinterface

`default_nettype wire

// File: sv/mtep_front.sv
// Front end: accept input beats and classify each byte for the parser.
// Depends on mtep_pkg and mtep_in_if.
`default_nettype none

module mtep_front (
  mtep_in_if.sink                  byte_i,
  input  var mtep_pkg::queue_stat_t q_stat_i,
  output logic                     push_o,
  output mtep_pkg::byte_class_t    class_o
);

  logic [7:0] b;

  assign b             = byte_i.data_byte;
  assign byte_i.ready  = !q_stat_i.full;
  assign push_o        = byte_i.valid && !q_stat_i.full;

  always_comb begin
    class_o             = '0;
    class_o.track_start = byte_i.track_start;
    class_o.data_byte   = b;
    class_o.is_status   = b[7];
    class_o.is_chan     = mtep_pkg::is_chan_status(b);
    class_o.is_sysex    = (b == mtep_pkg::STATUS_SYSEX) || (b == mtep_pkg::STATUS_EOX);
    class_o.is_meta     = (b == mtep_pkg::STATUS_META);
    class_o.is_eox      = (b == mtep_pkg::STATUS_EOX);
  end

endmodule

`default_nettype wire

// File: sv/mtep_queue.sv
// Short queue of classified bytes between front end and parser.
// Depends on mtep_pkg.
`default_nettype none

module mtep_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  var mtep_pkg::byte_class_t push_data_i,
  input  logic                      pop_i,
  output mtep_pkg::byte_class_t     pop_data_o,
  output mtep_pkg::queue_stat_t     stat_o
);

  localparam int unsigned AW = mtep_pkg::QUEUE_AW;
  localparam int unsigned CW = mtep_pkg::QUEUE_CW;

  mtep_pkg::byte_class_t mem_q [mtep_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign stat_o.full  = (count_q == CW'(mtep_pkg::QUEUE_DEPTH));
  assign stat_o.avail = (count_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.avail;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(mtep_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(mtep_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/mtep_back.sv
// Back end: track event state machine and registered output record.
// Depends on mtep_pkg and mtep_out_if.
`default_nettype none

module mtep_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  var mtep_pkg::queue_stat_t q_stat_i,
  input  var mtep_pkg::byte_class_t class_i,
  output logic                      pop_o,
  mtep_out_if.source                rec_o
);

  mtep_pkg::phase_e phase_q, phase_d;
  logic [31:0] delta_q, delta_d;
  logic [31:0] time_q, time_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  cur_q, cur_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  mtype_q, mtype_d;
  logic [31:0] mlen_q, mlen_d;
  logic [31:0] mrcv_q, mrcv_d;
  logic        run_q, run_d;
  logic        err_q, err_d;

  logic              out_valid_q;
  mtep_pkg::record_t out_q, rec_d;
  logic              emit;
  logic              running;
  logic [7:0]        st;
  logic [7:0]        b;

  assign b     = class_i.data_byte;
  assign pop_o = q_stat_i.avail && (!out_valid_q || rec_o.ready);

  always_comb begin
    phase_d = phase_q;
    delta_d = delta_q;
    time_d  = time_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    held_d  = held_q;
    mtype_d = mtype_q;
    mlen_d  = mlen_q;
    mrcv_d  = mrcv_q;
    run_d   = run_q;
    err_d   = err_q;
    emit    = 1'b0;
    rec_d   = '0;
    running = 1'b0;
    st      = '0;

    if (pop_o) begin
      if (class_i.track_start) begin
        phase_d = mtep_pkg::PH_START;
        delta_d = '0;
        time_d  = '0;
        prev_d  = '0;
        cur_d   = '0;
        held_d  = '0;
        mtype_d = '0;
        mlen_d  = '0;
        mrcv_d  = '0;
        run_d   = 1'b0;
        err_d   = 1'b0;
      end
      if (!err_d) begin
        if (phase_d == mtep_pkg::PH_START) begin
          delta_d = '0;
          mlen_d  = '0;
          mrcv_d  = '0;
          phase_d = mtep_pkg::PH_DELTA;
        end
        case (phase_d)
          mtep_pkg::PH_DELTA: begin
            delta_d = {delta_d[24:0], b[6:0]};
            if (!class_i.is_status) begin
              phase_d = mtep_pkg::PH_STATUS;
            end
          end
          mtep_pkg::PH_STATUS: begin
            running = !class_i.is_status;
            run_d   = 1'b1;
            if (running) begin
              st = prev_d;
            end else begin
              st = b;
              if (b == prev_d) begin
                run_d = 1'b0;
              end
            end
            time_d = time_d + delta_d;
            prev_d = st;
            if (running ? mtep_pkg::is_chan_status(st) : class_i.is_chan) begin
              cur_d   = st;
              phase_d = mtep_pkg::PH_P1;
              if (running) begin
                if (mtep_pkg::is_one_param(st)) begin
                  phase_d = mtep_pkg::PH_START;
                  emit    = 1'b1;
                  rec_d   = mtep_pkg::make_rec(mtep_pkg::KIND_CHAN, st, b, '0, '0, 1'b1, 1'b1);
                end else begin
                  held_d  = b;
                  phase_d = mtep_pkg::PH_P2;
                end
              end
            end else if (!running && class_i.is_sysex) begin
              cur_d   = st;
              phase_d = mtep_pkg::PH_SYSEX;
              emit    = 1'b1;
              rec_d   = mtep_pkg::make_rec(mtep_pkg::KIND_SYSEX, st, b, '0, '0, 1'b1, 1'b0);
            end else if (!running && class_i.is_meta) begin
              cur_d   = st;
              phase_d = mtep_pkg::PH_MTYPE;
            end else begin
              err_d = 1'b1;
              emit  = 1'b1;
              rec_d = mtep_pkg::make_rec(mtep_pkg::KIND_ERROR, st, '0, '0, '0, 1'b0, 1'b1);
            end
          end
          mtep_pkg::PH_P1: begin
            if (mtep_pkg::is_one_param(cur_d)) begin
              phase_d = mtep_pkg::PH_START;
              emit    = 1'b1;
              rec_d   = mtep_pkg::make_rec(mtep_pkg::KIND_CHAN, cur_d, b, '0, '0, 1'b1, 1'b1);
            end else begin
              held_d  = b;
              phase_d = mtep_pkg::PH_P2;
            end
          end
          mtep_pkg::PH_P2: begin
            phase_d = mtep_pkg::PH_START;
            emit    = 1'b1;
            rec_d   = mtep_pkg::make_rec(mtep_pkg::KIND_CHAN, cur_d, held_d, b, '0, 1'b1, 1'b1);
          end
          mtep_pkg::PH_SYSEX: begin
            emit  = 1'b1;
            rec_d = mtep_pkg::make_rec(mtep_pkg::KIND_SYSEX, cur_d, b, '0, '0, 1'b1,
                                       class_i.is_eox);
            if (class_i.is_eox) begin
              phase_d = mtep_pkg::PH_START;
            end
          end
          mtep_pkg::PH_MTYPE: begin
            mtype_d = b;
            phase_d = mtep_pkg::PH_MLEN;
          end
          mtep_pkg::PH_MLEN: begin
            mlen_d = {mlen_d[24:0], b[6:0]};
            if (!class_i.is_status) begin
              if (mlen_d == '0) begin
                phase_d = mtep_pkg::PH_START;
                emit    = 1'b1;
                rec_d   = mtep_pkg::make_rec(mtep_pkg::KIND_META, mtep_pkg::STATUS_META, '0, '0,
                                             mtype_d, 1'b0, 1'b1);
              end else begin
                phase_d = mtep_pkg::PH_MDATA;
              end
            end
          end
          mtep_pkg::PH_MDATA: begin
            mrcv_d = mrcv_d + 32'd1;
            emit   = 1'b1;
            rec_d  = mtep_pkg::make_rec(mtep_pkg::KIND_META, mtep_pkg::STATUS_META, b, '0,
                                        mtype_d, 1'b1, (mrcv_d == mlen_d));
            if (mrcv_d == mlen_d) begin
              phase_d = mtep_pkg::PH_START;
            end
          end
          default: begin
            phase_d = mtep_pkg::PH_START;
          end
        endcase
      end
    end
    rec_d.time_stamp      = time_d;
    rec_d.running_allowed = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mtep_pkg::PH_START;
      delta_q     <= '0;
      time_q      <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      held_q      <= '0;
      mtype_q     <= '0;
      mlen_q      <= '0;
      mrcv_q      <= '0;
      run_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      delta_q <= delta_d;
      time_q  <= time_d;
      prev_q  <= prev_d;
      cur_q   <= cur_d;
      held_q  <= held_d;
      mtype_q <= mtype_d;
      mlen_q  <= mlen_d;
      mrcv_q  <= mrcv_d;
      run_q   <= run_d;
      err_q   <= err_d;
      if (pop_o) begin
        out_valid_q <= emit;
      end else if (rec_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= rec_d;
    end
  end

  assign rec_o.valid           = out_valid_q;
  assign rec_o.record_kind     = out_q.record_kind;
  assign rec_o.time_stamp      = out_q.time_stamp;
  assign rec_o.status_value    = out_q.status_value;
  assign rec_o.param_first     = out_q.param_first;
  assign rec_o.param_second    = out_q.param_second;
  assign rec_o.meta_type       = out_q.meta_type;
  assign rec_o.payload_valid   = out_q.payload_valid;
  assign rec_o.last_of_event   = out_q.last_of_event;
  assign rec_o.running_allowed = out_q.running_allowed;

endmodule

`default_nettype wire

// File: sv/midi_track_event_parser.sv
// Top level of the MIDI track event parser: front end, byte queue, parser back end.
// Depends on mtep_pkg, mtep_if, mtep_front, mtep_queue and mtep_back.
//
// Usage
//   byte_i carries one track-chunk payload byte per beat, with track_start set on
//   the first byte of each track; that beat clears the time stamp and all parser
//   state before the byte is parsed. rec_o carries parsed records: complete
//   channel messages, one beat per SysEx byte, one beat per meta data byte (or one
//   empty beat for a zero-length meta event) and error records.
//   Each byte yields zero or one record. After an error record, bytes are taken
//   and dropped until the next track_start beat.
// Path and throughput
//   A byte's record passes through the queue and the output register before it is
//   offered on rec_o. One byte is parsed per cycle while the output register is free
//   or being taken; each parser state update holds delta shift, 32-bit time add, length compare.
// Reset and stalls
//   rst_ni clears the queue, the parser to event start and the output register.
//   When the receiver holds rec_o.ready low, the record waits in the output
//   register, the parser halts and the two-entry queue fills; byte_i.ready drops
//   only once the queue is full.
`default_nettype none

module midi_track_event_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtep_in_if.sink    byte_i,
  mtep_out_if.source rec_o
);

  mtep_pkg::queue_stat_t q_stat;
  mtep_pkg::byte_class_t push_class;
  mtep_pkg::byte_class_t pop_class;
  logic                  push;
  logic                  pop;

  // Classify each byte and push it while the queue has room.
  mtep_front u_front (
    .byte_i   (byte_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .class_o  (push_class)
  );

  // Hold classified bytes so that input and output stall independently.
  mtep_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_class),
    .pop_i       (pop),
    .pop_data_o  (pop_class),
    .stat_o      (q_stat)
  );

  // Advance the event state machine one byte per cycle while the output can move.
  mtep_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .class_i  (pop_class),
    .pop_o    (pop),
    .rec_o    (rec_o)
  );

endmodule

`default_nettype wire

// File: sv/mtep_checker.sv
// Port-level checks for the MIDI track event parser, bound to the top level.
// Depends on mtep_pkg and midi_track_event_parser.
`default_nettype none

module mtep_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rec_valid,
  input logic        rec_ready,
  input logic [1:0]  rec_kind,
  input logic [7:0]  rec_status,
  input logic [7:0]  rec_p1,
  input logic [7:0]  rec_p2,
  input logic [7:0]  rec_mtype,
  input logic        rec_pvalid,
  input logic        rec_last,
  input logic [31:0] rec_time
);

  // A stalled record keeps valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && !rec_ready |=> rec_valid)
    else $error("record dropped while stalled");

  // A stalled record keeps its status, first parameter and time stamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && !rec_ready |=> $stable(rec_status) && $stable(rec_p1) && $stable(rec_time))
    else $error("record payload changed while stalled");

  // Errors and channel messages are always single-record events.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && (rec_kind == mtep_pkg::KIND_ERROR) |->
      rec_last && !rec_pvalid && (rec_p1 == 8'd0) && (rec_mtype == 8'd0))
    else $error("malformed error record");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && (rec_kind == mtep_pkg::KIND_CHAN) |->
      rec_last && rec_pvalid && (rec_mtype == 8'd0) && rec_status[7])
    else $error("malformed channel record");

  // Meta records carry the meta status and no second parameter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && (rec_kind == mtep_pkg::KIND_META) |->
      (rec_status == mtep_pkg::STATUS_META) && (rec_p2 == 8'd0))
    else $error("malformed meta record");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rec_valid  (rec_o.valid),
  .rec_ready  (rec_o.ready),
  .rec_kind   (rec_o.record_kind),
  .rec_status (rec_o.status_value),
  .rec_p1     (rec_o.param_first),
  .rec_p2     (rec_o.param_second),
  .rec_mtype  (rec_o.meta_type),
  .rec_pvalid (rec_o.payload_valid),
  .rec_last   (rec_o.last_of_event),
  .rec_time   (rec_o.time_stamp)
);

`default_nettype wire

// File: dv/tb.sv
// Testbench for midi_track_event_parser: drives track bytes over the valid/ready input
// channel and checks each parsed record against an in-bench track parser.
// Depends on mtep_pkg, mtep_if and the parser RTL; reads no files.
`default_nettype none

module tb;
  import mtep_pkg::*;

  localparam int PERIOD          = 12;
  localparam int ITEMS           = 1150;
  localparam int WATCHDOG_CYCLES = 400000;
  localparam int DRAIN_CYCLES    = 8;

  // Tracks the parser state byte by byte and holds the records it should produce.
  class record_scoreboard;
    phase_e      phase;
    logic [31:0] delta, ticks, meta_len, meta_got;
    logic [7:0]  prev_st, cur_st, held_p1, held_type;
    bit          run_flag, halted;
    record_t     expected[$];
    int unsigned mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      phase     = PH_START;
      delta     = '0;
      ticks     = '0;
      meta_len  = '0;
      meta_got  = '0;
      prev_st   = '0;
      cur_st    = '0;
      held_p1   = '0;
      held_type = '0;
      run_flag  = 1'b0;
      halted    = 1'b0;
    endfunction

    // Queue one record stamped with the current time and running flag.
    function void expect_rec(kind_e k, logic [7:0] st, logic [7:0] p1, logic [7:0] p2,
                             logic [7:0] mt, bit pv, bit last);
      record_t r;
      r.record_kind     = k;
      r.time_stamp      = ticks;
      r.status_value    = st;
      r.param_first     = p1;
      r.param_second    = p2;
      r.meta_type       = mt;
      r.payload_valid   = pv;
      r.last_of_event   = last;
      r.running_allowed = run_flag;
      expected.insert(expected.size(), r);
    endfunction

    // First channel parameter: program change and channel pressure end here.
    function void take_first(logic [7:0] b);
      if (cur_st[7:4] == HI_PROGRAM || cur_st[7:4] == HI_PRESSURE) begin
        phase = PH_START;
        expect_rec(KIND_CHAN, cur_st, b, 8'h00, 8'h00, 1'b1, 1'b1);
      end else begin
        held_p1 = b;
        phase   = PH_P2;
      end
    endfunction

    function void note_byte(bit ts, logic [7:0] b);
      logic [7:0] st;
      bit         is_run;
      if (ts) clear();
      if (halted) return;
      if (phase == PH_START) begin
        delta    = '0;
        meta_len = '0;
        meta_got = '0;
        phase    = PH_DELTA;
      end
      case (phase)
        PH_DELTA: begin
          delta = (delta << 7) + {25'd0, b[6:0]};
          if (!b[7]) phase = PH_STATUS;
        end
        PH_STATUS: begin
          st       = b;
          is_run   = !b[7];
          run_flag = 1'b1;
          if (is_run) st = prev_st;
          else if (st == prev_st) run_flag = 1'b0;
          ticks   = ticks + delta;
          prev_st = st;
          if (st >= STATUS_CH_LO && st <= STATUS_CH_HI) begin
            cur_st = st;
            phase  = PH_P1;
            if (is_run) take_first(b);
          end else if (!is_run && (st == STATUS_SYSEX || st == STATUS_EOX)) begin
            cur_st = st;
            phase  = PH_SYSEX;
            expect_rec(KIND_SYSEX, st, b, 8'h00, 8'h00, 1'b1, 1'b0);
          end else if (!is_run && st == STATUS_META) begin
            cur_st = st;
            phase  = PH_MTYPE;
          end else begin
            halted = 1'b1;
            expect_rec(KIND_ERROR, st, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
          end
        end
        PH_P1: take_first(b);
        PH_P2: begin
          phase = PH_START;
          expect_rec(KIND_CHAN, cur_st, held_p1, b, 8'h00, 1'b1, 1'b1);
        end
        PH_SYSEX: begin
          if (b == STATUS_EOX) phase = PH_START;
          expect_rec(KIND_SYSEX, cur_st, b, 8'h00, 8'h00, 1'b1, b == STATUS_EOX);
        end
        PH_MTYPE: begin
          held_type = b;
          phase     = PH_MLEN;
        end
        PH_MLEN: begin
          meta_len = (meta_len << 7) + {25'd0, b[6:0]};
          if (!b[7]) begin
            if (meta_len == 0) begin
              phase = PH_START;
              expect_rec(KIND_META, STATUS_META, 8'h00, 8'h00, held_type, 1'b0, 1'b1);
            end else begin
              phase = PH_MDATA;
            end
          end
        end
        PH_MDATA: begin
          meta_got = meta_got + 1;
          if (meta_got == meta_len) phase = PH_START;
          expect_rec(KIND_META, STATUS_META, b, 8'h00, held_type, 1'b1, meta_got == meta_len);
        end
        default: phase = PH_START;
      endcase
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        mismatches++;
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, seen);
      end
    endfunction

    function void check_record(record_t got);
      record_t want;
      if (expected.size() == 0) begin
        mismatches++;
        $display("%0t unexpected record: expected none, actual kind %0d status %02h",
                 $time, got.record_kind, got.status_value);
        return;
      end
      want = expected.pop_front();
      compare("record_kind", want.record_kind, got.record_kind);
      compare("time_stamp", want.time_stamp, got.time_stamp);
      compare("status_value", want.status_value, got.status_value);
      compare("param_first", want.param_first, got.param_first);
      compare("param_second", want.param_second, got.param_second);
      compare("meta_type", want.meta_type, got.meta_type);
      compare("payload_valid", want.payload_valid, got.payload_valid);
      compare("last_of_event", want.last_of_event, got.last_of_event);
      compare("running_allowed", want.running_allowed, got.running_allowed);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mtep_in_if  byte_if ();
  mtep_out_if rec_if ();

  midi_track_event_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .rec_o  (rec_if)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  record_scoreboard board = new();
  record_t          seen_rec;

  int unsigned fed          = 0;  // beats that the parser acts on
  int unsigned send_gap_pct = 27;
  int unsigned recv_gap_pct = 45;
  bit          restart      = 1'b0;  // mark the next event byte as a track start

  // Opening script {track_start, byte}: two-parameter and running channel messages,
  // one-parameter message, empty SysEx, empty meta, unknown status with a dropped
  // byte after it, running status with no channel status, a full-width delta.
  logic [8:0] opening [0:30] = '{
    9'h100, 9'h080, 9'h000, 9'h0ff,
    9'h081, 9'h07f, 9'h07f, 9'h000,
    9'h000, 9'h0c5, 9'h07f,
    9'h000, 9'h0f0, 9'h0f7,
    9'h000, 9'h0ff, 9'h02f, 9'h000,
    9'h000, 9'h0f4,
    9'h055,
    9'h100, 9'h040,
    9'h18f, 9'h0ff, 9'h0ff, 9'h0ff, 9'h07f, 9'h0ef, 9'h012, 9'h034
  };

  // Sample both channels at the rising edge; note inputs before checking outputs.
  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      board.note_byte(byte_if.track_start, byte_if.data_byte);
    end
    if (rst_ni && rec_if.valid && rec_if.ready) begin
      seen_rec.record_kind     = kind_e'(rec_if.record_kind);
      seen_rec.time_stamp      = rec_if.time_stamp;
      seen_rec.status_value    = rec_if.status_value;
      seen_rec.param_first     = rec_if.param_first;
      seen_rec.param_second    = rec_if.param_second;
      seen_rec.meta_type       = rec_if.meta_type;
      seen_rec.payload_valid   = rec_if.payload_valid;
      seen_rec.last_of_event   = rec_if.last_of_event;
      seen_rec.running_allowed = rec_if.running_allowed;
      board.check_record(seen_rec);
    end
  end

  // Receiver: stall at random at the current rate, change only at the falling edge.
  initial begin
    rec_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rec_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Drive one beat: idle at random, hold valid until it is taken, return at a falling edge.
  task automatic send_byte(input bit ts, input logic [7:0] b);
    if (ts || !board.halted) fed++;
    if (fed < ITEMS / 3) begin
      send_gap_pct = 27;
      recv_gap_pct = 45;
    end else if (fed < 2 * ITEMS / 3) begin
      send_gap_pct = 45;
      recv_gap_pct = 27;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
    while ($urandom_range(99) < send_gap_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.track_start <= ts;
    byte_if.data_byte   <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    @(negedge clk_i);
  endtask

  task automatic put(input logic [7:0] b);
    send_byte(restart, b);
    restart = 1'b0;
  endtask

  function automatic logic [7:0] param_byte();
    return ($urandom_range(99) < 90) ? 8'($urandom_range(127)) : 8'($urandom);
  endfunction

  function automatic bit one_param(input logic [7:0] st);
    return st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE;
  endfunction

  // Variable-length delta: mostly one byte, now and then up to five so the time wraps.
  task automatic send_delta();
    int pick, n;
    pick = $urandom_range(99);
    n = (pick < 70) ? 1 : (pick < 90) ? 2 : (pick < 97) ? $urandom_range(3, 4) : 5;
    for (int i = 0; i < n; i++) begin
      put((i < n - 1) ? (8'($urandom) | 8'h80) : (8'($urandom) & 8'h7f));
    end
  endtask

  // One well-formed event with random content; a few are cut short by a new track,
  // and a few carry an unknown status. After an error, feed dropped bytes and restart.
  task automatic send_event();
    int         pick, len, pad;
    logic [7:0] st, prev, b;
    bit         prev_chan, cut;
    if ($urandom_range(99) < 3) restart = 1'b1;
    cut = ($urandom_range(99) < 3);
    send_delta();
    prev      = board.prev_st;
    prev_chan = (prev >= STATUS_CH_LO) && (prev <= STATUS_CH_HI);
    pick      = $urandom_range(99);
    // Steer most running-status picks away from a status that cannot run.
    if (pick >= 40 && pick < 62 && !prev_chan && $urandom_range(99) < 80) pick = 0;
    if (pick < 40) begin
      st = (prev_chan && $urandom_range(99) < 30) ?
           prev : 8'($urandom_range(STATUS_CH_LO, STATUS_CH_HI));
      put(st);
      if (!cut) begin
        put(param_byte());
        if (!one_param(st)) put(param_byte());
      end
    end else if (pick < 62) begin
      put(8'($urandom_range(127)));
      if (prev_chan && !one_param(prev)) put(param_byte());
    end else if (pick < 74) begin
      put(($urandom_range(99) < 80) ? STATUS_SYSEX : STATUS_EOX);
      if (!cut) begin
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom);
          if (b == STATUS_EOX) b = 8'h00;
          put(b);
        end
        put(STATUS_EOX);
      end
    end else if (pick < 92) begin
      put(STATUS_META);
      if (!cut) begin
        put(8'($urandom));
        pick = $urandom_range(99);
        if (pick < 4) begin
          // Length field that wraps past 32 bits down to two.
          put(8'h90);
          repeat (3) put(8'h80);
          put(8'h02);
          len = 2;
        end else begin
          len = $urandom_range(0, 5);
          pad = (pick < 20) ? $urandom_range(1, 2) : 0;
          repeat (pad) put(8'h80);
          put(8'(len));
        end
        repeat (len) put(8'($urandom));
      end
    end else begin
      do st = 8'($urandom_range(8'hf1, 8'hfe)); while (st == STATUS_EOX);
      put(st);
    end
    if (cut) restart = 1'b1;
    if (board.halted) begin
      repeat ($urandom_range(0, 3)) send_byte(1'b0, 8'($urandom));
      restart = 1'b1;
    end
  endtask

  initial begin
    byte_if.valid       = 1'b0;
    byte_if.track_start = 1'b0;
    byte_if.data_byte   = 8'h00;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening[i]) send_byte(opening[i][8], opening[i][7:0]);
    while (fed < ITEMS) send_event();
    byte_if.valid <= 1'b0;

    // Drain every outstanding record, then keep watching for stray records.
    while (board.expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(WATCHDOG_CYCLES * PERIOD);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
